// ===== rtl/ipv4p_pkg.sv =====
// Shared types and constants for the IPv4 dotted-text parser.
// No dependencies; imported by every module of the block.
package ipv4p_pkg;

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_ZERO   = 3'd1,
		PH_DIGITS = 3'd2,
		PH_TRAIL  = 3'd3,
		PH_FAIL   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_OCT = 2'd1,
		RX_HEX = 2'd2
	} radix_t;

	localparam int unsigned NUM_EARLIER = 3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	localparam logic [7:0] CH_UC_X  = 8'h58;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;

	localparam logic [31:0] LIM_BYTE  = 32'h0000_00ff;
	localparam logic [31:0] LIM_SHORT = 32'h0000_ffff;
	localparam logic [31:0] LIM_24    = 32'h00ff_ffff;

	// Running parse state, carried between the step logic and the top level.
	typedef struct packed {
		logic [31:0] value;
		radix_t      radix;
		phase_t      phase;
		logic [1:0]  count;
	} par_state_t;

	localparam par_state_t STATE_RESET = '{
		value: 32'd0, radix: RX_DEC, phase: PH_START, count: 2'd0
	};

	// Write of a closed part into the earlier-parts store.
	typedef struct packed {
		logic       en;
		logic [1:0] idx;
		logic [7:0] data;
	} part_wr_t;

	// Result produced on a NUL byte.
	typedef struct packed {
		logic        emit;
		logic        ok;
		logic [31:0] addr;
	} par_res_t;

endpackage

// ===== rtl/ipv4_dotted_text_parser.sv =====
// Top level of the IPv4 dotted-text parser: input register, parse state,
// earlier-parts store and result register. Depends on ipv4p_pkg,
// ipv4p_step and ipv4p_out.
//
// Usage
//   Input channel: in_valid / in_stall / char_in, one text byte per transfer.
//   A NUL byte ends the string and produces exactly one result; no other
//   byte produces a result.
//   Output channel: out_valid / out_stall / valid_res / address. address is
//   the composed a, a.b, a.b.c or a.b.c.d value, zero when valid_res is low.
//   Order: a byte is held in the input register, and its parse step
//   updates the parse state as it leaves; a NUL byte's result is then
//   registered in the result register, from which it can leave.
//   Throughput: one byte per clock unless stalled, bounded by the single
//   parse step (one shift-add and compare on the 32-bit part value) per cycle.
//   Stall: only a NUL byte waits, and only while the result register still
//   holds an untaken result; other bytes pass on regardless, so in_stall
//   rises only then.
//   Reset: arst_n clears the parse state, both valid flags and the part
//   count. The earlier-parts store is not cleared; only parts closed within
//   the current string are read.
module ipv4_dotted_text_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        valid_res,
	output logic [31:0] address
);
	import ipv4p_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;

	par_state_t state_q;
	par_state_t state_nxt;
	part_wr_t   part_wr;
	par_res_t   step_res;
	logic [7:0] parts_q [NUM_EARLIER];

	logic out_free;
	logic advance;

	// A byte in the input register moves on unless it is a NUL that
	// finds the result register occupied and stalled.
	assign advance  = !(char_s1 == CH_NUL) || out_free;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			char_s1 <= char_in;
	end

	ipv4p_step u_step (
		.cur   (state_q),
		.ch    (char_s1),
		.part0 (parts_q[0]),
		.part1 (parts_q[1]),
		.part2 (parts_q[2]),
		.nxt   (state_nxt),
		.wr    (part_wr),
		.res   (step_res)
	);

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// earlier parts, written as each dot closes a part
	always_ff @(posedge clk) begin
		if (valid_s1 && advance && part_wr.en)
			parts_q[part_wr.idx] <= part_wr.data;
	end

	ipv4p_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1 && advance && step_res.emit),
		.res       (step_res),
		.out_stall (out_stall),
		.free      (out_free),
		.out_valid (out_valid),
		.valid_res (valid_res),
		.address   (address)
	);

	// an invalid result always carries a zero address
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> address == 32'd0)
		else $error("invalid result with non-zero address");

	// a NUL step returns the parse state to its start
	a_nul_clears: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && char_s1 == CH_NUL
		|=> state_q.count == 2'd0 && state_q.phase == PH_START &&
		    state_q.value == 32'd0)
		else $error("state not cleared after end of string");

	// only a waiting NUL holds off the input
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && char_s1 == CH_NUL && out_valid && out_stall)
		else $error("input stalled without a pending result");

	// after a leading zero the part value is still zero
	a_zero_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_ZERO |-> state_q.value == 32'd0)
		else $error("non-zero value after leading zero");

endmodule

// ===== rtl/ipv4p_step.sv =====
// Per-byte next-state and result logic of the IPv4 dotted-text parser.
// Depends on ipv4p_pkg.
module ipv4p_step (
	input  ipv4p_pkg::par_state_t cur,
	input  logic [7:0]            ch,
	input  logic [7:0]            part0,
	input  logic [7:0]            part1,
	input  logic [7:0]            part2,
	output ipv4p_pkg::par_state_t nxt,
	output ipv4p_pkg::part_wr_t   wr,
	output ipv4p_pkg::par_res_t   res
);
	import ipv4p_pkg::*;

	logic [31:0] eff_val;
	radix_t      eff_rx;
	logic        run;
	logic [31:0] scaled;
	logic [3:0]  dig;

	// value times the radix, as shifts, plus one add for decimal
	always_comb begin
		case (eff_rx)
			RX_HEX:  scaled = {eff_val[27:0], 4'd0};
			RX_OCT:  scaled = {eff_val[28:0], 3'd0};
			default: scaled = {eff_val[28:0], 3'd0} + {eff_val[30:0], 1'b0};
		endcase
	end

	always_comb begin
		nxt     = cur;
		wr.en   = 1'b0;
		wr.idx  = cur.count;
		wr.data = cur.value[7:0];
		res     = '0;
		eff_val = cur.value;
		eff_rx  = cur.radix;
		run     = 1'b0;
		dig     = ch[3:0];

		if (ch == CH_NUL) begin
			res.emit = 1'b1;
			if (cur.phase inside {PH_START, PH_ZERO, PH_DIGITS, PH_TRAIL}) begin
				case (cur.count)
					2'd0: begin
						res.ok   = 1'b1;
						res.addr = cur.value;
					end
					2'd1: begin
						res.ok   = (cur.value <= LIM_24);
						res.addr = {part0, cur.value[23:0]};
					end
					2'd2: begin
						res.ok   = (cur.value <= LIM_SHORT);
						res.addr = {part0, part1, cur.value[15:0]};
					end
					default: begin
						res.ok   = (cur.value <= LIM_BYTE);
						res.addr = {part0, part1, part2, cur.value[7:0]};
					end
				endcase
				if (!res.ok)
					res.addr = 32'd0;
			end
			nxt = STATE_RESET;
		end else begin
			case (cur.phase)
				PH_START: begin
					nxt.value = 32'd0;
					if (ch == CH_ZERO) begin
						nxt.radix = RX_OCT;
						nxt.phase = PH_ZERO;
					end else begin
						eff_val = 32'd0;
						eff_rx  = RX_DEC;
						run     = 1'b1;
					end
				end
				PH_ZERO: begin
					if (ch == CH_LC_X || ch == CH_UC_X) begin
						nxt.radix = RX_HEX;
						nxt.phase = PH_DIGITS;
					end else begin
						eff_rx = RX_OCT;
						run    = 1'b1;
					end
				end
				PH_DIGITS: run = 1'b1;
				default: ;
			endcase

			if (run) begin
				nxt.radix = eff_rx;
				nxt.phase = PH_DIGITS;
				nxt.value = eff_val;
				if (ch inside {[CH_ZERO:CH_NINE]}) begin
					nxt.value = scaled + {28'd0, dig};
				end else if (eff_rx == RX_HEX &&
					(ch inside {[CH_LC_A:CH_LC_F], [CH_UC_A:CH_UC_F]})) begin
					// letter a..f: low nibble 1..6 weighs 10..15
					nxt.value = {eff_val[27:0], 4'd0} + {28'd0, dig + 4'd9};
				end else if (ch == CH_DOT) begin
					if (cur.count == 2'd3 || eff_val > LIM_BYTE) begin
						nxt.phase = PH_FAIL;
					end else begin
						wr.en     = 1'b1;
						wr.data   = eff_val[7:0];
						nxt.count = cur.count + 2'd1;
						nxt.value = 32'd0;
						nxt.radix = RX_DEC;
						nxt.phase = PH_START;
					end
				end else if (ch == CH_SPACE || (ch inside {[CH_TAB:CH_CR]})) begin
					nxt.phase = PH_TRAIL;
				end else begin
					nxt.phase = PH_FAIL;
				end
			end
		end
	end

endmodule

// ===== rtl/ipv4p_out.sv =====
// Result register of the IPv4 dotted-text parser, holding one result
// while the receiver stalls. Depends on ipv4p_pkg.
module ipv4p_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  ipv4p_pkg::par_res_t res,
	input  logic                out_stall,
	output logic                free,
	output logic                out_valid,
	output logic                valid_res,
	output logic [31:0]         address
);
	import ipv4p_pkg::*;

	logic out_valid_q;
	logic ok_q;
	logic [31:0] addr_q;

	assign free      = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign valid_res = ok_q;
	assign address   = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (free) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			ok_q   <= res.ok;
			addr_q <= res.addr;
		end
	end

endmodule
